### src/cfs_pkg.sv
`default_nettype none

package cfs_pkg;

   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_FIELDS     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DELIMITER_CHAR = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_QUOTE_CHAR     = 2'd2;

   localparam logic [3:0] MAX_FIELDS_RESET     = 4'd12;
   localparam logic [7:0] DELIMITER_CHAR_RESET = 8'd44;
   localparam logic [7:0] QUOTE_CHAR_RESET     = 8'd34;

   typedef enum logic [1:0] {
      PH_START,
      PH_UNQ,
      PH_QUO,
      PH_HELD
   } phase_type;

   typedef struct packed {
      logic [3:0] max_fields;
      logic [7:0] delimiter_char;
      logic [7:0] quote_char;
   } cfg_type;

   typedef struct packed {
      logic       line_done;
      logic       field_empty;
      logic       field_end;
      logic       quote_before;
      logic       byte_valid;
      logic [7:0] out_byte;
      logic [3:0] field_index;
   } rsp_type;

endpackage

`default_nettype wire

### src/cfs_parser.sv
`default_nettype none

module cfs_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_fire,
   input  wire logic [7:0]       in_byte,
   input  wire logic             line_end,
   input  wire cfs_pkg::cfg_type cfg,
   output logic                  res_valid,
   output cfs_pkg::rsp_type      res
);

   cfs_pkg::phase_type phase_ff, phase_in;
   logic [3:0]         fields_done_ff, fields_done_in;
   logic               is_delim, is_quote, room;

   assign is_delim = (in_byte == cfg.delimiter_char);
   assign is_quote = (in_byte == cfg.quote_char);
   assign room     = (fields_done_ff < cfg.max_fields);

   always_comb begin
      phase_in       = phase_ff;
      fields_done_in = fields_done_ff;
      if (req_fire) begin
         if (line_end) begin
            phase_in       = cfs_pkg::PH_START;
            fields_done_in = 4'd0;
         end else begin
            case (phase_ff)
               cfs_pkg::PH_UNQ: begin
                  if (is_delim) begin
                     phase_in       = cfs_pkg::PH_START;
                     fields_done_in = fields_done_ff + 4'd1;
                  end
               end
               cfs_pkg::PH_QUO: begin
                  if (is_quote) begin
                     phase_in = cfs_pkg::PH_HELD;
                  end
               end
               cfs_pkg::PH_HELD: begin
                  if (is_delim) begin
                     phase_in       = cfs_pkg::PH_START;
                     fields_done_in = fields_done_ff + 4'd1;
                  end else if (!is_quote) begin
                     phase_in = cfs_pkg::PH_QUO;
                  end
               end
               default: begin
                  phase_in = cfs_pkg::PH_START;
                  if (room) begin
                     if (is_quote) begin
                        phase_in = cfs_pkg::PH_QUO;
                     end else if (is_delim) begin
                        fields_done_in = fields_done_ff + 4'd1;
                     end else begin
                        phase_in = cfs_pkg::PH_UNQ;
                     end
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      res_valid       = 1'b0;
      res             = '0;
      res.field_index = fields_done_ff;
      if (line_end) begin
         res_valid     = req_fire;
         res.line_done = 1'b1;
         if (phase_ff == cfs_pkg::PH_START) begin
            res.field_index = 4'd0;
         end else begin
            res.field_end = 1'b1;
         end
      end else begin
         case (phase_ff)
            cfs_pkg::PH_UNQ: begin
               res_valid = req_fire;
               if (is_delim) begin
                  res.field_end = 1'b1;
               end else begin
                  res.out_byte   = in_byte;
                  res.byte_valid = 1'b1;
               end
            end
            cfs_pkg::PH_QUO: begin
               res_valid = req_fire && !is_quote;
               res.out_byte   = in_byte;
               res.byte_valid = 1'b1;
            end
            cfs_pkg::PH_HELD: begin
               res_valid = req_fire;
               if (is_delim) begin
                  res.field_end = 1'b1;
               end else if (is_quote) begin
                  res.out_byte   = cfg.quote_char;
                  res.byte_valid = 1'b1;
               end else begin
                  res.out_byte     = in_byte;
                  res.byte_valid   = 1'b1;
                  res.quote_before = 1'b1;
               end
            end
            default: begin
               res_valid = req_fire && room && !is_quote;
               if (is_delim) begin
                  res.field_end   = 1'b1;
                  res.field_empty = 1'b1;
               end else begin
                  res.out_byte   = in_byte;
                  res.byte_valid = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= cfs_pkg::PH_START;
         fields_done_ff <= 4'd0;
      end else begin
         phase_ff       <= phase_in;
         fields_done_ff <= fields_done_in;
      end
   end

endmodule

`default_nettype wire

### src/cfs_out_buf.sv
`default_nettype none

module cfs_out_buf (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             res_valid,
   input  wire cfs_pkg::rsp_type res,
   output logic                  in_ready,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output cfs_pkg::rsp_type      out_data
);

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   cfs_pkg::rsp_type out_data_ff, out_data_in;
   cfs_pkg::rsp_type skid_data_ff, skid_data_in;
   logic             out_free;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign out_free  = !out_valid_ff || out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_data_in  = res;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire

### src/csv_field_splitter.sv
// Splits a text line, streamed one byte per request with a closing line-end request, into
// up to max_fields fields and gives at most one result per request, registered in the output
// buffer once the request is taken; a byte and a line end can be offered every cycle and the
// block sustains one request per clock into its two-entry output buffer while req_tready is
// high, and req_tready only drops while two results wait for rsp_tready.
`default_nettype none

module csv_field_splitter (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [7:0]                     req_tdata,  // in_byte
   input  wire logic                           req_tlast,  // line_end
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [15:0]                         rsp_tdata,  // field_index, out_byte, zero pad
   output logic [3:0]                          rsp_tuser,  // byte_valid, quote_before,
                                                           // field_end, field_empty
   output logic                                rsp_tlast,  // line_done
   input  wire logic                           csr_we,
   input  wire logic [cfs_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [cfs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   cfs_pkg::cfg_type cfg_ff, cfg_in;
   cfs_pkg::rsp_type res, out_data;
   logic             res_valid, req_fire;

   assign req_fire = req_tvalid && req_tready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            cfs_pkg::CSR_MAX_FIELDS:     cfg_in.max_fields     = csr_wdata[3:0];
            cfs_pkg::CSR_DELIMITER_CHAR: cfg_in.delimiter_char = csr_wdata;
            cfs_pkg::CSR_QUOTE_CHAR:     cfg_in.quote_char     = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_fields     <= cfs_pkg::MAX_FIELDS_RESET;
         cfg_ff.delimiter_char <= cfs_pkg::DELIMITER_CHAR_RESET;
         cfg_ff.quote_char     <= cfs_pkg::QUOTE_CHAR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cfs_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .in_byte   (req_tdata),
      .line_end  (req_tlast),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   cfs_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {4'd0, out_data.out_byte, out_data.field_index};
   assign rsp_tuser = {out_data.field_empty, out_data.field_end,
                       out_data.quote_before, out_data.byte_valid};
   assign rsp_tlast = out_data.line_done;

endmodule

`default_nettype wire

### src/cfs_checker.sv
`default_nettype none

module cfs_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   input  wire logic                           req_tready,
   input  wire logic [7:0]                     req_tdata,
   input  wire logic                           req_tlast,
   input  wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   input  wire logic [15:0]                    rsp_tdata,
   input  wire logic [3:0]                     rsp_tuser,
   input  wire logic                           rsp_tlast,
   input  wire logic                           csr_we,
   input  wire logic [cfs_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [cfs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // A result offered but not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("stalled result was dropped");

   // Nothing is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // An empty field is a closing result and never the line-end result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> rsp_tuser[2] && !rsp_tlast && !rsp_tuser[0])
      else $error("empty-field flag on a wrong result");

   // A byte is only carried with its valid flag, and a held quote only precedes a byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[11:4] == 8'd0 && !rsp_tuser[1])
      else $error("byte data without byte_valid");

endmodule

bind csv_field_splitter cfs_checker u_cfs_checker (.*);

`default_nettype wire
